// File: src/polygon_cell_raster_assert.svh
// ----------------------------------------------------------------------------
// polygon_cell_raster assertion macros
// concurrent checks clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef POLYGON_CELL_RASTER_ASSERT_SVH
`define POLYGON_CELL_RASTER_ASSERT_SVH

// same-cycle implication
`define PCR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// shared constants and the command format passed from front to back
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int MAX_CORNERS = 64;
  localparam int GRID_SIZE   = 256;
  localparam int ADDR_W      = $clog2(MAX_CORNERS);
  localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int GRID_W      = 9;
  localparam int CENTER_W    = 12;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 2 * DIFF_W;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH = 2'd1;

  // operation codes
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic                       func;
    logic                       restart;
    logic                       in_grid;
    logic signed [15:0]         vertex_x;
    logic signed [15:0]         vertex_y;
    logic        [CENTER_W-1:0] center_x;
    logic        [CENTER_W-1:0] center_y;
  } cmd_t;

endpackage

// File: src/pcr_front.sv
// ----------------------------------------------------------------------------
// pcr_front
// accepts input beats, holds grid registers, checks cell range and
// forms cell-centre coordinates for the back end
// ----------------------------------------------------------------------------
module pcr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [47:0]        s_tdata,   // vertex_x, vertex_y, cell_x, cell_y
  input  logic [1:0]         s_tuser,   // func, restart
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output pcr_pkg::cmd_t      q_cmd
);
  import pcr_pkg::*;

  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_depth;
  logic [7:0]        cell_x;
  logic [7:0]        cell_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_W'(256);
      grid_depth <= GRID_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH: grid_width <= cfg_data;
        REG_GRID_DEPTH: grid_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cell_x   = s_tdata[39:32];
  assign cell_y   = s_tdata[47:40];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.func     = s_tuser[0];
    q_cmd.restart  = s_tuser[1];
    q_cmd.vertex_x = s_tdata[15:0];
    q_cmd.vertex_y = s_tdata[31:16];
    q_cmd.in_grid  = ({1'b0, cell_x} < grid_width) && ({1'b0, cell_x} < GRID_W'(GRID_SIZE))
                  && ({1'b0, cell_y} < grid_depth) && ({1'b0, cell_y} < GRID_W'(GRID_SIZE));
    // cell centre is c*16+8 in 4-fraction-bit units
    q_cmd.center_x = {cell_x, 4'b1000};
    q_cmd.center_y = {cell_y, 4'b1000};
  end

endmodule

// File: src/pcr_queue.sv
// ----------------------------------------------------------------------------
// pcr_queue
// short command queue decoupling the front end from the back end
// ----------------------------------------------------------------------------
module pcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcr_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output pcr_pkg::cmd_t pop_cmd
);
  import pcr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full    = (fill == FILL_W'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: src/pcr_back.sv
// ----------------------------------------------------------------------------
// pcr_back
// corner table, append handling and the edge-scan pipeline for queries,
// with the result register on the output stream
// ----------------------------------------------------------------------------
`include "polygon_cell_raster_assert.svh"

module pcr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  pcr_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // inside_res
  output logic [0:0]    m_tuser    // status
);
  import pcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  logic [CNT_W-1:0] corner_count;

  // corner table
  logic [31:0]       corner_table [MAX_CORNERS];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;

  // result register
  logic res_valid;
  logic res_inside;
  logic res_status;
  logic out_free;
  logic res_load;
  logic res_load_inside;
  logic res_load_status;

  // append decode
  logic [CNT_W-1:0] base;
  logic             table_full;
  logic             start_scan;

  // query context
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic                inside_acc;
  logic                inside_upd;

  // read issue
  logic             iss_busy;
  logic             iss_prime;
  logic [CNT_W-1:0] iss_idx;
  logic [CNT_W-1:0] last_idx;
  logic             iss_last;

  // stage 1: read data valid
  logic s1_vld, s1_prime, s1_last;
  logic [31:0] prev_corner;

  // stage 2: differences
  logic s2_vld, s2_last, s2_cond, s2_dpos;
  logic signed [DIFF_W-1:0] s2_dxp, s2_span, s2_dxe, s2_dyp;

  // stage 3: products
  logic s3_vld, s3_last, s3_cond, s3_dpos;
  logic signed [PROD_W-1:0] s3_lhs, s3_rhs;

  // stage 2 combinational inputs
  logic signed [DIFF_W-1:0] xi, yi, xj, yj, px, py;
  logic                     crossing;

  assign out_free = !res_valid || m_tready;
  assign m_tvalid = res_valid;
  assign m_tdata  = {7'b0, res_inside};
  assign m_tuser  = res_status;

  assign base       = q_cmd.restart ? '0 : corner_count;
  assign table_full = (base >= CNT_W'(MAX_CORNERS));
  assign last_idx   = corner_count - 1'b1;
  assign iss_last   = !iss_prime && (iss_idx == last_idx);

  always_comb begin
    q_pop           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = base[ADDR_W-1:0];
    wr_data         = {q_cmd.vertex_y, q_cmd.vertex_x};
    res_load        = 1'b0;
    res_load_inside = 1'b0;
    res_load_status = 1'b0;
    start_scan      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_cmd.func == FUNC_APPEND) begin
            wr_en           = !table_full;
            res_load        = 1'b1;
            res_load_status = table_full;
          end else if (!q_cmd.in_grid || corner_count == '0) begin
            res_load = 1'b1;
          end else begin
            start_scan = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_load        = 1'b1;
          res_load_inside = inside_acc;
        end
      end
      default: ;
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      corner_table[wr_addr] <= wr_data;
    end
    rd_data <= corner_table[rd_addr];
  end

  assign rd_addr = iss_prime ? last_idx[ADDR_W-1:0] : iss_idx[ADDR_W-1:0];

  // edge i runs from the corner just read back to the one before it
  always_comb begin
    xi = DIFF_W'($signed(rd_data[15:0]));
    yi = DIFF_W'($signed(rd_data[31:16]));
    xj = DIFF_W'($signed(prev_corner[15:0]));
    yj = DIFF_W'($signed(prev_corner[31:16]));
    px = $signed({{(DIFF_W - CENTER_W){1'b0}}, center_x});
    py = $signed({{(DIFF_W - CENTER_W){1'b0}}, center_y});
  end

  // span sign decides which way the cross-multiplied compare points
  assign crossing   = s3_dpos ? (s3_lhs < s3_rhs) : (s3_lhs > s3_rhs);
  assign inside_upd = inside_acc ^ (s3_cond && crossing);

  always_ff @(posedge clk) begin
    if (start_scan) begin
      center_x <= q_cmd.center_x;
      center_y <= q_cmd.center_y;
    end
    if (s1_vld) begin
      prev_corner <= rd_data;
    end
    s2_dxp  <= px - xi;
    s2_span <= yj - yi;
    s2_dxe  <= xj - xi;
    s2_dyp  <= py - yi;
    s2_cond <= (yi > py) != (yj > py);
    s2_dpos <= (yj > yi);
    s3_lhs  <= PROD_W'(s2_dxp) * PROD_W'(s2_span);
    s3_rhs  <= PROD_W'(s2_dxe) * PROD_W'(s2_dyp);
    s3_cond <= s2_cond;
    s3_dpos <= s2_dpos;
    if (res_load) begin
      res_inside <= res_load_inside;
      res_status <= res_load_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      corner_count <= '0;
      res_valid    <= 1'b0;
      inside_acc   <= 1'b0;
      iss_busy     <= 1'b0;
      iss_prime    <= 1'b0;
      iss_idx      <= '0;
      s1_vld       <= 1'b0;
      s1_prime     <= 1'b0;
      s1_last      <= 1'b0;
      s2_vld       <= 1'b0;
      s2_last      <= 1'b0;
      s3_vld       <= 1'b0;
      s3_last      <= 1'b0;
    end else begin
      if (wr_en) begin
        corner_count <= base + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end

      // read issue: closing corner first, then corners in order
      if (start_scan) begin
        iss_busy  <= 1'b1;
        iss_prime <= 1'b1;
        iss_idx   <= '0;
      end else if (iss_busy) begin
        if (iss_prime) begin
          iss_prime <= 1'b0;
        end else begin
          iss_idx <= iss_idx + 1'b1;
          if (iss_last) begin
            iss_busy <= 1'b0;
          end
        end
      end

      s1_vld   <= iss_busy;
      s1_prime <= iss_prime;
      s1_last  <= iss_busy && iss_last;
      s2_vld   <= s1_vld && !s1_prime;
      s2_last  <= s1_vld && s1_last;
      s3_vld   <= s2_vld;
      s3_last  <= s2_vld && s2_last;

      unique case (state)
        ST_IDLE: begin
          if (start_scan) begin
            state      <= ST_SCAN;
            inside_acc <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (s3_vld) begin
            inside_acc <= inside_upd;
            if (s3_last) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PCR_ASSERT_NOW(a_count_bound, 1'b1, corner_count <= CNT_W'(MAX_CORNERS), "corner count overflow")
  `PCR_ASSERT_NOW(a_write_idle, wr_en, state == ST_IDLE && !iss_busy, "table write during scan")
  `PCR_ASSERT_NOW(a_last_in_scan, s3_vld, state == ST_SCAN, "edge result outside scan")
  `PCR_ASSERT_NEXT(a_done_after_last, s3_vld && s3_last, state == ST_DONE && !s1_vld,
                   "scan did not finish after last edge")

endmodule

// File: src/polygon_cell_raster.sv
// an append, an out-of-grid or an empty-table query gives its result beat through the
// command queue and the result register; a query with corners in range also passes the
// edge-scan pipeline and the done state; one append per cycle while m_tready holds;
// a query holds the back end for its scan, one edge per cycle on the single read port
// reset: corner table empty, grid_width and grid_depth 256, command queue empty
// ----------------------------------------------------------------------------
// polygon_cell_raster
// point-in-polygon rasterizer: stores polygon corners and answers even-odd
// ray-casting tests for grid cell centers
// ----------------------------------------------------------------------------
module polygon_cell_raster (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,    // vertex_x, vertex_y, cell_x, cell_y
  input  logic [1:0]  s_tuser,    // func, restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // inside_res
  output logic [0:0]  m_tuser,    // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import pcr_pkg::*;

  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  pcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  pcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd)
  );

  pcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
